@@ rtl/hmed_pkg.sv @@
// Package for the HTTP message end detector: phase codes, widths, helpers.
// Used by every module of the block; depends on nothing.
package hmed_pkg;

  localparam int unsigned DefLengthBits = 32;
  localparam logic [15:0] DefMaxHeader = 16'd8192;

  localparam logic [3:0] PhStart   = 4'd0;
  localparam logic [3:0] PhHeader  = 4'd1;
  localparam logic [3:0] PhTeVal   = 4'd2;
  localparam logic [3:0] PhClVal   = 4'd3;
  localparam logic [3:0] PhBody    = 4'd4;
  localparam logic [3:0] PhCsize   = 4'd5;
  localparam logic [3:0] PhCext    = 4'd6;
  localparam logic [3:0] PhCdata   = 4'd7;
  localparam logic [3:0] PhCend    = 4'd8;
  localparam logic [3:0] PhTrailer = 4'd9;
  localparam logic [3:0] PhDone    = 4'd10;
  localparam logic [3:0] PhFailed  = 4'd11;

  localparam logic [1:0] StPending  = 2'd0;
  localparam logic [1:0] StComplete = 2'd1;
  localparam logic [1:0] StLimit    = 2'd2;
  localparam logic [1:0] StFail     = 2'd3;

  localparam logic        CfgHeadOnly  = 1'b0;
  localparam logic        CfgMaxHeader = 1'b1;

  // One byte after classification, as it travels from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       is_lf;
    logic       is_cr;
    logic       is_sp;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] nib;
    logic [7:0] lower;
  } cls_t;

  function automatic logic [7:0] kw_te_char(input logic [4:0] p);
    logic [7:0] c;
    case (p)
      5'd0: c = "t";  5'd1: c = "r";  5'd2: c = "a";  5'd3: c = "n";
      5'd4: c = "s";  5'd5: c = "f";  5'd6: c = "e";  5'd7: c = "r";
      5'd8: c = "-";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "c";
      5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
      5'd16: c = "g"; 5'd17: c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_cl_char(input logic [4:0] p);
    logic [7:0] c;
    case (p)
      5'd0: c = "c";  5'd1: c = "o";  5'd2: c = "n";  5'd3: c = "t";
      5'd4: c = "e";  5'd5: c = "n";  5'd6: c = "t";  5'd7: c = "-";
      5'd8: c = "l";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "g";
      5'd12: c = "t"; 5'd13: c = "h"; 5'd14: c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_chunked_char(input logic [4:0] p);
    logic [7:0] c;
    case (p)
      5'd0: c = "c"; 5'd1: c = "h"; 5'd2: c = "u"; 5'd3: c = "n";
      5'd4: c = "k"; 5'd5: c = "e"; 5'd6: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_http_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0: c = "H"; 3'd1: c = "T"; 3'd2: c = "T"; 3'd3: c = "P"; 3'd4: c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/hmed_front.sv @@
// Front stage: takes input words, classifies each byte and registers it.
// Depends on hmed_pkg.
module hmed_front
  import hmed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  input  logic       in_first_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cls_t       out_cls_o
);

  logic valid_q, valid_d;
  cls_t cls_q, cls_d;
  logic [7:0] b;

  assign in_ready_o = !valid_q || out_ready_i;
  assign b = in_data_i;

  always_comb begin
    cls_d = cls_q;
    if (in_valid_i && in_ready_o) begin
      cls_d.data   = b;
      cls_d.first  = in_first_i;
      cls_d.is_lf  = (b == 8'h0A);
      cls_d.is_cr  = (b == 8'h0D);
      cls_d.is_sp  = (b == 8'h20);
      cls_d.is_dec = (b >= "0") && (b <= "9");
      cls_d.lower  = ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
      cls_d.is_hex = 1'b1;
      if ((b >= "0") && (b <= "9")) cls_d.nib = 4'(b - "0");
      else if ((b >= "A") && (b <= "F")) cls_d.nib = 4'(b - "A" + 8'd10);
      else if ((b >= "a") && (b <= "f")) cls_d.nib = 4'(b - "a" + 8'd10);
      else begin
        cls_d.nib    = 4'd0;
        cls_d.is_hex = 1'b0;
      end
    end
  end

  assign valid_d = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

  assign out_valid_o = valid_q;
  assign out_cls_o   = cls_q;

endmodule

@@ rtl/hmed_fifo.sv @@
// Short queue of classified bytes between front and back stages.
// Depends on hmed_pkg.
module hmed_fifo
  import hmed_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cls_t in_cls_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cls_t out_cls_o
);

  cls_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cls_o   = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cls_i;
  end

endmodule

@@ rtl/hmed_back.sv @@
// Back stage: framing state machine and counters, one byte a cycle unless a
// stalled result holds it, with a registered result word. Depends on hmed_pkg.
module hmed_back
  import hmed_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = DefLengthBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hdr_only_i,
  input  logic [15:0] max_header_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cls_t        in_cls_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_status_o,
  output logic [31:0] out_length_o
);

  localparam logic [LENGTH_BITS-1:0] LMax = '1;
  localparam logic [LENGTH_BITS-1:0] LDiv10 = LMax / 10;
  localparam logic [LENGTH_BITS-1:0] LMod10 = LMax % 10;

  logic [3:0]             phase_q, phase_d;
  logic [LENGTH_BITS-1:0] bcnt_q, bcnt_d;
  logic [15:0]            hcnt_q, hcnt_d;
  logic [LENGTH_BITS-1:0] blen_q, blen_d;
  logic                   lknown_q, lknown_d;
  logic                   chunked_q, chunked_d;
  logic [4:0]             kpos_q, kpos_d;
  logic [1:0]             kalive_q, kalive_d;
  logic [LENGTH_BITS-1:0] crem_q, crem_d;
  logic                   als_q, als_d;
  logic                   crs_q, crs_d;
  logic [2:0]             scp_q, scp_d;
  logic                   nobody_q, nobody_d;
  logic                   ovalid_q;
  logic [1:0]             ostat_q, ostat_d;
  logic [31:0]            olen_q, olen_d;

  logic fire;
  assign in_ready_o = !ovalid_q || out_ready_i;
  assign fire = in_valid_i && in_ready_o;

  always_comb begin
    logic [1:0]             st;
    logic                   ended, in_hdr, hb, go_hdr;
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] idx;
    logic [16:0]            hc1;
    logic [3:0]             dg;

    phase_d = phase_q; bcnt_d = bcnt_q; hcnt_d = hcnt_q; blen_d = blen_q;
    lknown_d = lknown_q; chunked_d = chunked_q; kpos_d = kpos_q;
    kalive_d = kalive_q; crem_d = crem_q; als_d = als_q; crs_d = crs_q;
    scp_d = scp_q; nobody_d = nobody_q;
    st = StPending; ended = 1'b0; hb = 1'b0; go_hdr = 1'b0;
    b = in_cls_i.data; idx = '0; hc1 = '0; dg = 4'(in_cls_i.data - "0");

    if (in_cls_i.first) begin
      phase_d = PhStart; bcnt_d = '0; hcnt_d = '0; blen_d = '0;
      lknown_d = 1'b1; chunked_d = 1'b0; kpos_d = '0; kalive_d = '0;
      crem_d = '0; als_d = 1'b0; crs_d = 1'b0; scp_d = '0; nobody_d = 1'b0;
    end
    in_hdr = (phase_d <= PhClVal);

    if (phase_d == PhDone || phase_d == PhFailed) begin
      st = (phase_d == PhFailed) ? StFail : StPending;
      in_hdr = 1'b0;
    end else begin
      bcnt_d = bcnt_d + 1'b1;
      idx = bcnt_d - 1'b1;
      case (phase_d)
        PhStart: begin
          if (in_cls_i.is_cr || in_cls_i.is_lf) begin
            if (scp_d >= 3'd1 && scp_d <= 3'd3) lknown_d = 1'b0;
            scp_d = 3'd4;
            if (in_cls_i.is_lf) go_hdr = 1'b1;
          end else if (scp_d == 3'd4) begin
            scp_d = scp_d;
          end else if (idx < 5) begin
            if (b != kw_http_char(idx[2:0])) scp_d = 3'd4;
          end else if (scp_d == 3'd0) begin
            if (in_cls_i.is_sp) scp_d = 3'd1;
          end else if (scp_d == 3'd1) begin
            if (b == "1") begin nobody_d = 1'b1; scp_d = 3'd4; end
            else if (b == "2" || b == "3") scp_d = 3'd2;
            else begin lknown_d = 1'b0; scp_d = 3'd4; end
          end else if (scp_d == 3'd2) begin
            if (b == "0") scp_d = 3'd3;
            else begin lknown_d = 1'b0; scp_d = 3'd4; end
          end else begin
            if (b == "4") nobody_d = 1'b1;
            else lknown_d = 1'b0;
            scp_d = 3'd4;
          end
        end
        PhHeader: hb = 1'b1;
        PhTeVal: begin
          if (in_cls_i.is_sp && kpos_d == 5'd0) begin
            hb = 1'b0;
          end else if (kpos_d < 5'd7 && in_cls_i.lower == kw_chunked_char(kpos_d)) begin
            kpos_d = kpos_d + 5'd1;
            if (kpos_d == 5'd7) begin
              chunked_d = 1'b1; kpos_d = '0; phase_d = PhHeader;
            end
          end else begin
            kpos_d = '0; hb = 1'b1;
          end
        end
        PhClVal: begin
          if (in_cls_i.is_sp && kpos_d == 5'd0) begin
            hb = 1'b0;
          end else if (in_cls_i.is_dec) begin
            if (blen_d > LDiv10 ||
                (blen_d == LDiv10 && LENGTH_BITS'(dg) > LMod10)) blen_d = LMax;
            else blen_d = (blen_d << 3) + (blen_d << 1) + LENGTH_BITS'(dg);
            kpos_d = 5'd1;
          end else begin
            kpos_d = '0; hb = 1'b1;
          end
        end
        PhBody: begin
          blen_d = blen_d - 1'b1;
          if (blen_d == '0) begin phase_d = PhDone; st = StComplete; end
        end
        PhCsize: begin
          if (in_cls_i.is_hex) begin
            if (crem_d[LENGTH_BITS-1 -: 4] != 4'd0) begin
              phase_d = PhFailed; st = StFail;
            end else crem_d = {crem_d[LENGTH_BITS-5:0], in_cls_i.nib};
          end else if (crem_d == '0) begin
            phase_d = PhTrailer;
            if (in_cls_i.is_lf) als_d = 1'b1;
            else als_d = 1'b0;
          end else begin
            phase_d = in_cls_i.is_lf ? PhCdata : PhCext;
          end
        end
        PhCext: if (in_cls_i.is_lf) phase_d = PhCdata;
        PhCdata: begin
          crem_d = crem_d - 1'b1;
          if (crem_d == '0) begin phase_d = PhCend; crs_d = 1'b0; end
        end
        PhCend: begin
          if (in_cls_i.is_lf) begin
            phase_d = PhCsize; crem_d = '0; crs_d = 1'b0;
          end else if (in_cls_i.is_cr && !crs_d) crs_d = 1'b1;
          else begin phase_d = PhFailed; st = StFail; end
        end
        default: begin
          if (in_cls_i.is_lf) begin
            if (als_d) begin phase_d = PhDone; st = StComplete; end
            else als_d = 1'b1;
          end else if (!in_cls_i.is_cr) als_d = 1'b0;
        end
      endcase

      // Shared header-line handling for the header and value phases.
      if (hb) begin
        if (in_cls_i.is_lf) begin
          if (als_d) ended = 1'b1;
          else go_hdr = 1'b1;
        end else begin
          phase_d = PhHeader;
          if (in_cls_i.is_cr) kalive_d = 2'd0;
          else begin
            als_d = 1'b0;
            if (kalive_d != 2'd0) begin
              if (kalive_d[0] && !(kpos_d < 5'd18 &&
                  in_cls_i.lower == kw_te_char(kpos_d))) kalive_d[0] = 1'b0;
              if (kalive_d[1] && !(kpos_d < 5'd15 &&
                  in_cls_i.lower == kw_cl_char(kpos_d))) kalive_d[1] = 1'b0;
              kpos_d = kpos_d + 5'd1;
              if (kalive_d[0] && kpos_d == 5'd18) begin
                phase_d = PhTeVal; kpos_d = '0; kalive_d = '0;
              end else if (kalive_d[1] && kpos_d == 5'd15) begin
                phase_d = PhClVal; lknown_d = 1'b1; blen_d = '0;
                kpos_d = '0; kalive_d = '0;
              end else if (kalive_d == 2'd0) kpos_d = '0;
            end
          end
        end
      end
      if (go_hdr) begin
        phase_d = PhHeader; als_d = 1'b1; kpos_d = '0; kalive_d = 2'd3;
      end

      if (in_hdr) begin
        if (ended) begin
          if (hdr_only_i || nobody_d) begin phase_d = PhDone; st = StComplete; end
          else if (chunked_d) begin phase_d = PhCsize; crem_d = '0; end
          else if (!lknown_d) begin phase_d = PhFailed; st = StFail; end
          else if (blen_d == '0) begin phase_d = PhDone; st = StComplete; end
          else phase_d = PhBody;
        end else begin
          hc1 = {1'b0, hcnt_d} + 17'd1;
          if (hc1 > {1'b0, max_header_i}) begin
            phase_d = PhDone; st = StLimit;
          end else hcnt_d = hc1[16] ? 16'hFFFF : hc1[15:0];
        end
      end
    end

    ostat_d = st;
    if (st == StComplete || st == StLimit) olen_d = 32'(bcnt_d);
    else olen_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart; bcnt_q <= '0; hcnt_q <= '0; blen_q <= '0;
      lknown_q <= 1'b1; chunked_q <= 1'b0; kpos_q <= '0; kalive_q <= '0;
      crem_q <= '0; als_q <= 1'b0; crs_q <= 1'b0; scp_q <= '0;
      nobody_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d; bcnt_q <= bcnt_d; hcnt_q <= hcnt_d; blen_q <= blen_d;
        lknown_q <= lknown_d; chunked_q <= chunked_d; kpos_q <= kpos_d;
        kalive_q <= kalive_d; crem_q <= crem_d; als_q <= als_d; crs_q <= crs_d;
        scp_q <= scp_d; nobody_q <= nobody_d;
      end
      if (in_ready_o) ovalid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ostat_q <= ostat_d;
      olen_q  <= olen_d;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostat_q;
  assign out_length_o = olen_q;

endmodule

@@ rtl/http_message_end_detector.sv @@
// Top level of the HTTP message end detector: configuration registers,
// front classifier, queue and framing back stage. Depends on hmed_pkg.
//
//  Channel  Direction  Payload
//  s_axis   in         tdata[7:0] data_byte, tuser[0] first_byte
//  m_axis   out        tdata[1:0] status, tdata[33:2] message_length
//  cfg      in         cfg_we_i, cfg_idx_i (0 header-only mode, 1 max_header_bytes)
//
// One word is accepted per cycle unless back-pressure from a stalled output
// holds the input, and each gives one result word. On its way a word passes
// the classifier register, the two-entry queue and the result register of the
// framing state machine. Reset clears all message state; max_header_bytes
// comes up as 8192.
// A stall on the output only stops the back stage; the queue and the front
// keep taking words until both fill.
module http_message_end_detector
  import hmed_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = DefLengthBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [1:0] status, [33:2] message_length
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic        hdr_only_q;
  logic [15:0] max_hdr_q;

  // The user must write configuration only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_only_q <= 1'b0;
      max_hdr_q  <= DefMaxHeader;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeadOnly:  hdr_only_q <= cfg_wdata_i[0];
        CfgMaxHeader: max_hdr_q  <= cfg_wdata_i;
        default:      max_hdr_q  <= max_hdr_q;
      endcase
    end
  end

  logic f_valid, f_ready, q_valid, q_ready;
  cls_t f_cls, q_cls;
  logic [1:0]  status;
  logic [31:0] mlen;

  hmed_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_first_i(s_axis_tuser),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_cls_o(f_cls)
  );

  hmed_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_cls_i(f_cls),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_cls_o(q_cls)
  );

  hmed_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk_i, .rst_ni,
    .hdr_only_i(hdr_only_q), .max_header_i(max_hdr_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_cls_i(q_cls),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_status_o(status), .out_length_o(mlen)
  );

  assign m_axis_tdata = {6'd0, mlen, status};

  // A pending or failed result never carries a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == StPending || status == StFail) |-> mlen == 32'd0)
    else $error("length on non-complete result");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

endmodule

@@ tb/tb_http_message_end_detector.sv @@
// Testbench for http_message_end_detector: drives HTTP message bytes, predicts
// status and length per byte, checks every result word. Depends on hmed_pkg.
`timescale 1ns / 100ps

module tb_http_message_end_detector
  import hmed_pkg::*;
;

  localparam int unsigned TimeoutCycles = 400000;

  // One predicted result word.
  typedef struct {
    logic [1:0]  status;
    logic [31:0] msg_len;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgHeadOnly;
  logic [15:0] cfg_wdata_i = '0;

  http_message_end_detector uut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow of the framing state machine.
  logic        sh_hdr_only;
  logic [15:0] sh_max_hdr;
  logic [3:0]  sh_phase;
  logic [31:0] sh_count;
  logic [15:0] sh_hdr_count;
  logic [31:0] sh_body_len;
  logic        sh_len_known, sh_chunked, sh_no_body, sh_line_start, sh_cr_seen;
  logic [4:0]  sh_kw_pos;
  logic [1:0]  sh_kw_alive;
  logic [31:0] sh_chunk_left;
  logic [2:0]  sh_code_pos;

  verdict_t expected_results[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_off_cycles = 0;

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic void clear_message();
    sh_phase = PhStart;
    sh_count = '0;
    sh_hdr_count = '0;
    sh_body_len = '0;
    sh_len_known = 1'b1;
    sh_chunked = 1'b0;
    sh_kw_pos = '0;
    sh_kw_alive = '0;
    sh_chunk_left = '0;
    sh_line_start = 1'b0;
    sh_cr_seen = 1'b0;
    sh_code_pos = '0;
    sh_no_body = 1'b0;
  endfunction

  // Ordinary header byte; returns 1 when an empty line ends the header.
  function automatic logic header_char(input logic [7:0] b);
    logic [7:0] c;
    if (b == 8'h0a) begin
      if (sh_line_start) return 1'b1;
      sh_line_start = 1'b1;
      sh_kw_pos = '0;
      sh_kw_alive = 2'd3;
      sh_phase = PhHeader;
      return 1'b0;
    end
    sh_phase = PhHeader;
    if (b == 8'h0d) begin
      sh_kw_alive = '0;
      return 1'b0;
    end
    sh_line_start = 1'b0;
    if (sh_kw_alive != 0) begin
      c = lower_case(b);
      if (sh_kw_alive[0] && !(sh_kw_pos < 18 && c == kw_te_char(sh_kw_pos)))
        sh_kw_alive[0] = 1'b0;
      if (sh_kw_alive[1] && !(sh_kw_pos < 15 && c == kw_cl_char(sh_kw_pos)))
        sh_kw_alive[1] = 1'b0;
      sh_kw_pos = sh_kw_pos + 5'd1;
      if (sh_kw_alive[0] && sh_kw_pos == 18) begin
        sh_phase = PhTeVal;
        sh_kw_pos = '0;
        sh_kw_alive = '0;
      end else if (sh_kw_alive[1] && sh_kw_pos == 15) begin
        sh_phase = PhClVal;
        sh_len_known = 1'b1;
        sh_body_len = '0;
        sh_kw_pos = '0;
        sh_kw_alive = '0;
      end else if (sh_kw_alive == 0) begin
        sh_kw_pos = '0;
      end
    end
    return 1'b0;
  endfunction

  // Start line: looks for the "HTTP/" prefix and a no-body status code.
  function automatic void start_line_char(input logic [7:0] b);
    logic [31:0] idx;
    idx = sh_count - 32'd1;
    if (b == 8'h0d || b == 8'h0a) begin
      if (sh_code_pos >= 1 && sh_code_pos <= 3) sh_len_known = 1'b0;
      sh_code_pos = 3'd4;
      if (b == 8'h0a) begin
        sh_phase = PhHeader;
        sh_line_start = 1'b1;
        sh_kw_pos = '0;
        sh_kw_alive = 2'd3;
      end
    end else if (sh_code_pos != 4) begin
      if (idx < 5) begin
        if (b != kw_http_char(idx[2:0])) sh_code_pos = 3'd4;
      end else if (sh_code_pos == 0) begin
        if (b == " ") sh_code_pos = 3'd1;
      end else if (sh_code_pos == 1) begin
        if (b == "1") begin
          sh_no_body = 1'b1;
          sh_code_pos = 3'd4;
        end else if (b == "2" || b == "3") begin
          sh_code_pos = 3'd2;
        end else begin
          sh_len_known = 1'b0;
          sh_code_pos = 3'd4;
        end
      end else if (sh_code_pos == 2) begin
        if (b == "0") sh_code_pos = 3'd3;
        else begin
          sh_len_known = 1'b0;
          sh_code_pos = 3'd4;
        end
      end else begin
        if (b == "4") sh_no_body = 1'b1;
        else sh_len_known = 1'b0;
        sh_code_pos = 3'd4;
      end
    end
  endfunction

  function automatic logic [1:0] trailer_char(input logic [7:0] b);
    if (b == 8'h0a) begin
      if (sh_line_start) begin
        sh_phase = PhDone;
        return StComplete;
      end
      sh_line_start = 1'b1;
    end else if (b != 8'h0d) begin
      sh_line_start = 1'b0;
    end
    return StPending;
  endfunction

  // Advances the shadow by one byte and returns the expected result word.
  function automatic verdict_t predict_framing(input logic [7:0] b, input logic first);
    verdict_t   v;
    logic [1:0] st;
    logic       ended, in_hdr;
    logic [16:0] cnt;
    int         h, d;
    st = StPending;
    ended = 1'b0;
    if (first) clear_message();
    if (sh_phase == PhDone || sh_phase == PhFailed) begin
      v.status = (sh_phase == PhFailed) ? StFail : StPending;
      v.msg_len = '0;
      return v;
    end
    sh_count = sh_count + 32'd1;
    in_hdr = sh_phase <= PhClVal;
    case (sh_phase)
      PhStart: start_line_char(b);
      PhHeader: ended = header_char(b);
      PhTeVal: begin
        if (!(b == " " && sh_kw_pos == 0)) begin
          if (sh_kw_pos < 7 && lower_case(b) == kw_chunked_char(sh_kw_pos)) begin
            sh_kw_pos = sh_kw_pos + 5'd1;
            if (sh_kw_pos == 7) begin
              sh_chunked = 1'b1;
              sh_kw_pos = '0;
              sh_phase = PhHeader;
            end
          end else begin
            sh_kw_pos = '0;
            ended = header_char(b);
          end
        end
      end
      PhClVal: begin
        if (!(b == " " && sh_kw_pos == 0)) begin
          if (b >= "0" && b <= "9") begin
            d = b - "0";
            if (sh_body_len > (32'hffff_ffff - d) / 10) sh_body_len = 32'hffff_ffff;
            else sh_body_len = sh_body_len * 10 + d;
            sh_kw_pos = 5'd1;
          end else begin
            sh_kw_pos = '0;
            ended = header_char(b);
          end
        end
      end
      PhBody: begin
        sh_body_len = sh_body_len - 32'd1;
        if (sh_body_len == 0) begin
          sh_phase = PhDone;
          st = StComplete;
        end
      end
      PhCsize: begin
        h = hex_digit(b);
        if (h >= 0) begin
          if (sh_chunk_left > 32'h0fff_ffff) begin
            sh_phase = PhFailed;
            st = StFail;
          end else sh_chunk_left = {sh_chunk_left[27:0], h[3:0]};
        end else if (sh_chunk_left == 0) begin
          sh_phase = PhTrailer;
          sh_line_start = 1'b0;
          st = trailer_char(b);
        end else begin
          sh_phase = (b == 8'h0a) ? PhCdata : PhCext;
        end
      end
      PhCext: if (b == 8'h0a) sh_phase = PhCdata;
      PhCdata: begin
        sh_chunk_left = sh_chunk_left - 32'd1;
        if (sh_chunk_left == 0) begin
          sh_phase = PhCend;
          sh_cr_seen = 1'b0;
        end
      end
      PhCend: begin
        if (b == 8'h0a) begin
          sh_phase = PhCsize;
          sh_chunk_left = '0;
          sh_cr_seen = 1'b0;
        end else if (b == 8'h0d && !sh_cr_seen) begin
          sh_cr_seen = 1'b1;
        end else begin
          sh_phase = PhFailed;
          st = StFail;
        end
      end
      default: st = trailer_char(b);
    endcase
    if (in_hdr) begin
      if (ended) begin
        // End of header: decide how the body is framed.
        if (sh_hdr_only || sh_no_body) begin
          sh_phase = PhDone;
          st = StComplete;
        end else if (sh_chunked) begin
          sh_phase = PhCsize;
          sh_chunk_left = '0;
        end else if (!sh_len_known) begin
          sh_phase = PhFailed;
          st = StFail;
        end else if (sh_body_len == 0) begin
          sh_phase = PhDone;
          st = StComplete;
        end else sh_phase = PhBody;
      end else begin
        cnt = sh_hdr_count + 17'd1;
        if (cnt > sh_max_hdr) begin
          sh_phase = PhDone;
          st = StLimit;
        end else sh_hdr_count = (cnt > 17'hffff) ? 16'hffff : cnt[15:0];
      end
    end
    v.status = st;
    v.msg_len = (st == StComplete || st == StLimit) ? sh_count : '0;
    return v;
  endfunction

  // Sends one word; the prediction is made when the handshake completes.
  task automatic send_byte(input logic [7:0] b, input logic first);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
      @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tuser = first;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_framing(b, first));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_text(input string s, input logic first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], first && i == 0);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgHeadOnly) sh_hdr_only = val[0];
    else sh_max_hdr = val;
  endtask

  // Waits until every result has arrived and the pipeline has drained.
  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Result checker: compares each accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                   m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[33:2] !== want.msg_len) begin
          $display("%0t: length expected %0d actual %0d", $realtime, want.msg_len,
                   m_axis_tdata[33:2]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("** http_message_end_detector: FAILED **");
      $finish;
    end
  end

  // Random bytes, any value, weighted toward LF, CR and space.
  function automatic logic [7:0] rand_text_byte();
    case ($urandom_range(9, 0))
      0: return 8'h0a;
      1: return 8'h0d;
      2: return " ";
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic string hex_string(input int unsigned v);
    return $sformatf("%h", v);
  endfunction

  // One message of a random kind with random content, not always well formed.
  task automatic send_random_message(output int len);
    string eol, s, lbl;
    int    n, kind;
    if ($urandom_range(1, 0)) eol = "\r\n";
    else eol = "\n";
    kind = $urandom_range(5, 0);
    case ($urandom_range(4, 0))
      0: s = {"HTTP/1.1 204 No Content", eol};
      1: s = {"HTTP/1.0 1", $sformatf("%0d", $urandom_range(99, 0)), " x", eol};
      2: s = {"HTTP/1.1 304", eol};
      3: s = {"GET /", $sformatf("%0d", $urandom_range(999, 0)), " HTTP/1.1", eol};
      default: s = {"HTTP/1.1 ", $sformatf("%0d", $urandom_range(599, 200)), " OK", eol};
    endcase
    if ($urandom_range(1, 0)) s = {s, "Host: a", eol};
    if (kind <= 1) begin
      n = $urandom_range(12, 0);
      if ($urandom_range(1, 0)) lbl = "content-LENGTH: ";
      else lbl = "Content-Length:";
      s = {s, lbl, $sformatf("%0d", n), eol, eol};
      for (int i = 0; i < n; i++) s = {s, string'(rand_text_byte())};
    end else if (kind <= 3) begin
      if ($urandom_range(1, 0)) lbl = "Transfer-Encoding: chunked";
      else lbl = "TRANSFER-encoding:CHUNKED";
      s = {s, lbl, eol, eol};
      repeat ($urandom_range(2, 0)) begin
        n = $urandom_range(6, 1);
        s = {s, hex_string(n)};
        if ($urandom_range(3, 0) == 0) s = {s, ";ext=1"};
        s = {s, eol};
        for (int i = 0; i < n; i++) s = {s, string'(rand_text_byte())};
        s = {s, eol};
      end
      s = {s, "0", eol};
      if ($urandom_range(1, 0)) s = {s, "X-T: 1", eol};
      s = {s, eol};
    end else if (kind == 4) begin
      s = {s, eol};
    end else begin
      // Noise: random bytes that may break the framing anywhere.
      repeat ($urandom_range(20, 1)) s = {s, string'(rand_text_byte())};
    end
    if ($urandom_range(3, 0) == 0) s = {s, "zz"};
    len = s.len();
    send_text(s, 1'b1);
  endtask

  task automatic test_status_codes();
    send_text("HTTP/1.1 204 No Content\r\n\r\n", 1'b1);
    send_text("HTTP/1.1 304 NM\n\n", 1'b1);
    send_text("HTTP/1.1 100 C\r\n\r\nxx", 1'b1);
    send_text("HTTP/1.1 20\r\n\r\n", 1'b1);
    send_text("HTTP/1.1 200 OK\r\n\r\n", 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_content_length();
    send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\nCONTENT-LENGTH: 2\r\n\r\nabc", 1'b1);
    send_text("POST / HTTP/1.1\ncontent-length:0\n\n", 1'b1);
    send_text("GET / x\nContent-Length: 99999999999\n\nab", 1'b1);
  endtask

  task automatic test_chunked();
    send_text({"HTTP/1.1 200 OK\r\nContent-Length: 5\r\nTransfer-Encoding: chunked\r\n",
               "\r\n3;e\r\nabc\r\nA\nxxxxxxxxxx\n0\r\nT: 1\r\n\r\n"}, 1'b1);
    send_text("GET / x\ntransfer-encoding: chunked\n\n2\nabX", 1'b1);
    send_text("GET / x\ntransfer-encoding: chunked\n\n123456789", 1'b1);
    send_text("GET / x\ntransfer-encoding: chunked\n\nfFfFfFfF\nq", 1'b1);
  endtask

  task automatic test_config();
    write_reg(CfgHeadOnly, 16'h0001);
    send_text("HTTP/1.1 200 OK\r\nContent-Length: 9\r\n\r\n", 1'b1);
    drain();
    write_reg(CfgHeadOnly, 16'hfffe);
    write_reg(CfgMaxHeader, 16'd0);
    send_text("GE", 1'b1);
    drain();
    write_reg(CfgMaxHeader, 16'd5);
    send_text("HTTP/1.1 200", 1'b1);
    drain();
    write_reg(CfgMaxHeader, 16'hffff);
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    int sent, len;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      send_random_message(len);
      sent += len;
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 60;
    send_text("HTTP/1.1 200 OK\r\nContent-Length: 4\r\n\r\nabcd", 1'b1);
    drain();
  endtask

  initial begin
    sh_hdr_only = 1'b0;
    sh_max_hdr = 16'd8192;
    clear_message();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_status_codes();
    test_content_length();
    test_chunked();
    drain();
    test_config();
    test_backpressure();
    test_random(90, 0, 0);
    test_random(90, 63, 0);
    write_reg(CfgMaxHeader, 16'd40);
    test_random(90, 0, 63);
    write_reg(CfgMaxHeader, 16'd8192);
    write_reg(CfgHeadOnly, 16'd1);
    test_random(60, 23, 23);
    write_reg(CfgHeadOnly, 16'd0);
    test_random(90, 23, 23);
    if (fail_count == 0) $display("** http_message_end_detector: PASSED **");
    else $display("** http_message_end_detector: FAILED **");
    $finish;
  end

endmodule
